// ===== sv/wav_pcm_stream_parser_macros.svh =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_macros.svh
// Assertion macros for the WAVE stream parser. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_PARSER_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every clock edge outside reset.
`define WPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition now implies a condition at the next edge.
`define WPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define WPS_ASSERT(name, prop, msg)
`define WPS_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ===== sv/wps_pkg.sv =====
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the RIFF/WAVE PCM stream parser.
// ----------------------------------------------------------------------------
package wps_pkg;

  // Chunk tags, first byte in the top lane
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [15:0] CHANS_STEREO  = 16'd2;
  localparam logic [15:0] BITS_SIXTEEN  = 16'd16;
  localparam logic [31:0] FMT_BODY_LEN  = 32'd16;
  localparam logic [7:0]  SIGN_FLIP     = 8'h80;

  // Result kinds
  localparam logic [1:0] KIND_FORMAT  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_BAD_TAG   = 3'd0;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd1;
  localparam logic [2:0] ERR_NO_CHUNK  = 3'd2;
  localparam logic [2:0] ERR_FMT_SHORT = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } wps_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  payload_byte;
    logic [31:0] sample_freq;
    logic        is_stereo;
    logic        is_sixteen_bit;
    logic [31:0] payload_length;
    logic        last_payload;
  } wps_result_t;

  function automatic wps_result_t wps_error_result(input logic [2:0] code);
    wps_result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

// ===== sv/wps_in_if.sv =====
// ----------------------------------------------------------------------------
// wps_in_if
// Byte channel into the parser: one file byte and its end-of-file flag.
// ----------------------------------------------------------------------------
interface wps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== sv/wps_out_if.sv =====
// ----------------------------------------------------------------------------
// wps_out_if
// Result channel out of the parser: format info, payload byte or error.
// ----------------------------------------------------------------------------
interface wps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [7:0]  payload_byte;
  logic [31:0] sample_freq;
  logic        is_stereo;
  logic        is_sixteen_bit;
  logic [31:0] payload_length;
  logic        last_payload;

  modport source (
    output valid, output kind, output error_code, output payload_byte,
    output sample_freq, output is_stereo, output is_sixteen_bit,
    output payload_length, output last_payload, input ready
  );
  modport sink (
    input valid, input kind, input error_code, input payload_byte,
    input sample_freq, input is_stereo, input is_sixteen_bit,
    input payload_length, input last_payload, output ready
  );
endinterface

// ===== sv/wps_in_reg.sv =====
// ----------------------------------------------------------------------------
// wps_in_reg
// Input register: holds one byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module wps_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  wps_pkg::wps_item_t  in_item_i,
  output logic                in_ready_o,
  input  logic                take_i,
  output logic                item_valid_o,
  output wps_pkg::wps_item_t  item_o
);
  import wps_pkg::*;

  logic      valid_q;
  wps_item_t item_q;

  // Refill in the same cycle the held word moves on
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== sv/wps_parse_core.sv =====
// ----------------------------------------------------------------------------
// wps_parse_core
// Header parser FSM and result register: one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module wps_parse_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  wps_pkg::wps_item_t   item_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output wps_pkg::wps_result_t res_o,
  input  logic                 res_ready_i
);
  import wps_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_TOTAL     = 4'd1,
    PH_WAVE      = 4'd2,
    PH_FMT_HDR   = 4'd3,
    PH_SKIP_FMT  = 4'd4,
    PH_FMT_BODY  = 4'd5,
    PH_FMT_REST  = 4'd6,
    PH_DATA_HDR  = 4'd7,
    PH_SKIP_DATA = 4'd8,
    PH_PAYLOAD   = 4'd9,
    PH_IDLE      = 4'd10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] freq_q, freq_d;
  logic [31:0] rem_q, rem_d;

  logic        res_valid_q;
  wps_result_t res_q;
  logic        has_res;
  wps_result_t res_d;

  // Take a byte when the result register is free or draining
  assign take_o      = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic [7:0]  b;
    logic        eof;
    logic [2:0]  c;
    logic [31:0] len_base;

    b        = item_i.data_byte;
    eof      = item_i.end_of_file;
    c        = cnt_q[2:0];
    len_base = '0;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    tag_d   = tag_q;
    len_d   = len_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    bits_d  = bits_q;
    freq_d  = freq_q;
    rem_d   = rem_q;
    has_res = 1'b0;
    res_d   = '0;

    case (phase_q)
      PH_RIFF, PH_WAVE: begin
        tag_d = {tag_q[23:0], b};
        cnt_d = cnt_q + 4'd1;
        if (cnt_d == 4'd4) begin
          cnt_d = '0;
          if (phase_q == PH_RIFF) begin
            if (tag_d != TAG_RIFF) begin
              has_res = 1'b1;
              res_d   = wps_error_result(ERR_BAD_TAG);
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_TOTAL;
            end
          end else begin
            if (tag_d != TAG_WAVE) begin
              has_res = 1'b1;
              res_d   = wps_error_result(ERR_BAD_TAG);
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_FMT_HDR;
            end
          end
        end
      end
      PH_TOTAL: begin
        // RIFF size field is not used
        cnt_d = cnt_q + 4'd1;
        if (cnt_d == 4'd4) begin
          cnt_d   = '0;
          phase_d = PH_WAVE;
        end
      end
      PH_FMT_HDR, PH_DATA_HDR: begin
        len_base = (c == 3'd0) ? 32'd0 : len_q;
        len_d    = len_base;
        if (!c[2]) begin
          tag_d = {tag_q[23:0], b};
        end else begin
          len_d = len_base | ({24'd0, b} << {c[1:0], 3'b000});
        end
        cnt_d = {1'b0, c} + 4'd1;
        if (c == 3'd7) begin
          cnt_d = '0;
          if (phase_q == PH_FMT_HDR) begin
            if (tag_d == TAG_FMT) begin
              if (len_d < FMT_BODY_LEN) begin
                has_res = 1'b1;
                res_d   = wps_error_result(ERR_FMT_SHORT);
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_FMT_BODY;
              end
            end else if (len_d == 32'd0) begin
              has_res = 1'b1;
              res_d   = wps_error_result(ERR_NO_CHUNK);
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_SKIP_FMT;
            end
          end else begin
            if (tag_d == TAG_DATA) begin
              rem_d = len_d;
              if (eof && len_d != 32'd0) begin
                has_res = 1'b1;
                res_d   = wps_error_result(ERR_TRUNC);
                phase_d = PH_IDLE;
              end else begin
                has_res              = 1'b1;
                res_d.kind           = KIND_FORMAT;
                res_d.sample_freq    = freq_q;
                res_d.is_stereo      = (chan_q == CHANS_STEREO);
                res_d.is_sixteen_bit = (bits_q == BITS_SIXTEEN);
                res_d.payload_length = len_d;
                phase_d = (len_d != 32'd0) ? PH_PAYLOAD : PH_IDLE;
              end
            end else if (len_d == 32'd0) begin
              has_res = 1'b1;
              res_d   = wps_error_result(ERR_NO_CHUNK);
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_SKIP_DATA;
            end
          end
        end
      end
      PH_SKIP_FMT, PH_SKIP_DATA, PH_FMT_REST: begin
        len_d = len_q - 32'd1;
        if (len_d == 32'd0) begin
          cnt_d   = '0;
          phase_d = (phase_q == PH_SKIP_FMT) ? PH_FMT_HDR : PH_DATA_HDR;
        end
      end
      PH_FMT_BODY: begin
        if (cnt_q < 4'd2) begin
          fmt_d = fmt_q | ({8'd0, b} << {cnt_q[0], 3'b000});
        end else if (cnt_q < 4'd4) begin
          chan_d = chan_q | ({8'd0, b} << {cnt_q[0], 3'b000});
        end else if (cnt_q < 4'd8) begin
          freq_d = freq_q | ({24'd0, b} << {cnt_q[1:0], 3'b000});
        end else if (cnt_q >= 4'd14) begin
          bits_d = bits_q | ({8'd0, b} << {cnt_q[0], 3'b000});
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (fmt_d != FMT_PCM) begin
            has_res = 1'b1;
            res_d   = wps_error_result(ERR_NOT_PCM);
            phase_d = PH_IDLE;
          end else begin
            len_d   = len_q - FMT_BODY_LEN;
            phase_d = (len_d == 32'd0) ? PH_DATA_HDR : PH_FMT_REST;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_q - 32'd1;
        has_res = 1'b1;
        if (rem_d != 32'd0 && eof) begin
          res_d   = wps_error_result(ERR_TRUNC);
          phase_d = PH_IDLE;
        end else begin
          res_d.kind         = KIND_PAYLOAD;
          res_d.payload_byte = (bits_q == BITS_SIXTEEN) ? b : (b ^ SIGN_FLIP);
          res_d.last_payload = (rem_d == 32'd0);
          if (rem_d == 32'd0) begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_IDLE: begin
        // drop bytes until the end flag
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (eof) begin
      if (!has_res && phase_d != PH_IDLE) begin
        has_res = 1'b1;
        if (phase_d inside {PH_RIFF, PH_TOTAL, PH_WAVE}) begin
          res_d = wps_error_result(ERR_BAD_TAG);
        end else if (phase_d inside {PH_FMT_BODY, PH_PAYLOAD}) begin
          res_d = wps_error_result(ERR_TRUNC);
        end else begin
          res_d = wps_error_result(ERR_NO_CHUNK);
        end
      end
      // restart for the next file
      phase_d = PH_RIFF;
      cnt_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      fmt_d   = '0;
      chan_d  = '0;
      bits_d  = '0;
      freq_d  = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      cnt_q       <= '0;
      tag_q       <= '0;
      len_q       <= '0;
      fmt_q       <= '0;
      chan_q      <= '0;
      bits_q      <= '0;
      freq_q      <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (take_o) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        tag_q       <= tag_d;
        len_q       <= len_d;
        fmt_q       <= fmt_d;
        chan_q      <= chan_d;
        bits_q      <= bits_d;
        freq_q      <= freq_d;
        rem_q       <= rem_d;
        res_valid_q <= has_res;
        if (has_res) begin
          res_q <= res_d;
        end
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/wav_pcm_stream_parser.sv =====
// Each accepted byte passes from the input register through the parse state
// update into the result register, which holds any result word until taken.
// Throughput: one byte per cycle, sustained, with both sides flowing.
// The rate is set by the parse state update between the input
// register and the result register.
// Reset: rst_ni is asynchronous; it clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// RIFF/WAVE PCM header parser: checks tags, reads the fmt chunk, finds the
// data chunk, then emits a format word and every payload byte, or an error.
// ----------------------------------------------------------------------------
`include "wav_pcm_stream_parser_macros.svh"

module wav_pcm_stream_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  wps_in_if.sink    byte_i,
  wps_out_if.source result_o
);
  import wps_pkg::*;

  wps_item_t   in_item;
  wps_item_t   item;
  logic        item_valid;
  logic        take;
  logic        res_valid;
  wps_result_t res;

  assign in_item.data_byte   = byte_i.data_byte;
  assign in_item.end_of_file = byte_i.end_of_file;

  wps_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (byte_i.ready),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wps_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (result_o.ready)
  );

  assign result_o.valid          = res_valid;
  assign result_o.kind           = res.kind;
  assign result_o.error_code     = res.error_code;
  assign result_o.payload_byte   = res.payload_byte;
  assign result_o.sample_freq    = res.sample_freq;
  assign result_o.is_stereo      = res.is_stereo;
  assign result_o.is_sixteen_bit = res.is_sixteen_bit;
  assign result_o.payload_length = res.payload_length;
  assign result_o.last_payload   = res.last_payload;

  `WPS_ASSERT(a_last_only_on_payload,
    !(res_valid && res.last_payload) || res.kind == KIND_PAYLOAD,
    "last_payload set on a non-payload result")

  `WPS_ASSERT(a_code_only_on_error,
    !(res_valid && res.kind != KIND_ERROR) || res.error_code == ERR_BAD_TAG,
    "error code set on a non-error result")

  `WPS_ASSERT_NEXT(a_hold_byte_on_stall,
    item_valid && res_valid && !result_o.ready,
    item_valid && $stable(item),
    "input register lost a byte while results stalled")

endmodule
